// ===== hw/rtl/urb_pkg.sv =====
// shared types and register codes for the uart register block
package urb_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_LINE  = 2'd2;

    // register offsets
    localparam logic [2:0] REG_DATA = 3'd0;
    localparam logic [2:0] REG_IER  = 3'd1;
    localparam logic [2:0] REG_FIFO = 3'd2;
    localparam logic [2:0] REG_LCR  = 3'd3;
    localparam logic [2:0] REG_MCR  = 3'd4;
    localparam logic [2:0] REG_LSR  = 3'd5;
    localparam logic [2:0] REG_MSR  = 3'd6;
    localparam logic [2:0] REG_SCR  = 3'd7;

    // bit positions
    localparam int LCR_DLAB_BIT  = 7;
    localparam int MCR_LOOP_BIT  = 4;
    localparam int FCR_CLEAR_BIT = 1;

    // fixed read values
    localparam logic [7:0] IIR_NONE      = 8'h01;
    localparam logic [7:0] IIR_NONE_FIFO = 8'hC1;
    localparam logic [7:0] LSR_TX_EMPTY  = 8'h60;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] offset;
        logic [7:0] write_data;
        logic [7:0] line_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
    } t_out_word;

endpackage

// ===== hw/rtl/urb_stream_if.sv =====
// valid/ready channel carrying one word of type t
interface urb_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/uart_register_block_with_loopback_core.sv =====
// 16550-style uart register file with receive fifo and internal loopback
//
// One word per cycle: every register access or line byte is accepted in the
// cycle it is offered while the result side keeps up, and its result is
// registered in the main result stage. The receive fifo lives in a synchronous
// memory of RX_DEPTH bytes; the pop read is issued at the accepting edge and
// its data is picked up by the result stage from the memory read register.
// A two-entry result buffer (main register plus skid) keeps i_item.ready a
// registered signal and lets a new word in while a result still waits. No
// clearing pass after reset: fifo entries are only read after they were
// written.
module uart_register_block_with_loopback_core
    import urb_pkg::*;
#(
    parameter int RX_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    urb_stream_if.sink     i_item,
    urb_stream_if.source   o_result
);

    localparam int AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int CW = $clog2(RX_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(RX_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(RX_DEPTH);

    // register file state
    logic [15:0]   r_div, n_div;
    logic [3:0]    r_ier, n_ier;
    logic [7:0]    r_lcr, n_lcr;
    logic [4:0]    r_mcr, n_mcr;
    logic          r_fen, n_fen;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovr, n_ovr;
    logic [7:0]    r_scr, n_scr;

    // receive fifo memory
    logic [7:0]    r_mem [RX_DEPTH];
    logic [7:0]    r_mem_q;

    // result buffer: main stage and skid
    logic          r_m_valid, r_s_valid;
    logic          r_m_sel_mem;
    logic [7:0]    r_m_rd;
    logic          r_m_txv;
    logic [7:0]    r_m_txb;
    t_out_word     r_s_word;
    t_out_word     w_m_word;

    logic          w_in_fire;
    logic          w_out_fire;
    logic          w_push;
    logic          w_push_ok;
    logic [7:0]    w_push_byte;
    logic          w_sel_mem;
    logic [7:0]    w_rd;
    logic          w_txv;
    logic [7:0]    w_txb;
    logic          w_dlab;
    logic          w_loop;
    logic [7:0]    w_msr;
    t_in_word      w_in;

    function automatic logic [AW-1:0] f_next_idx(input logic [AW-1:0] idx);
        f_next_idx = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    assign w_in       = i_item.data;
    assign i_item.ready = !r_s_valid;
    assign w_in_fire  = i_item.valid && !r_s_valid;
    assign w_out_fire = o_result.valid && o_result.ready;

    assign w_dlab = r_lcr[LCR_DLAB_BIT];
    assign w_loop = r_mcr[MCR_LOOP_BIT];
    assign w_msr  = w_loop ? {r_mcr[3], r_mcr[2], r_mcr[0], r_mcr[1], 4'b0000} : 8'h00;

    // decode and state update of the accepted word
    always_comb begin
        n_div   = r_div;
        n_ier   = r_ier;
        n_lcr   = r_lcr;
        n_mcr   = r_mcr;
        n_fen   = r_fen;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_ovr   = r_ovr;
        n_scr   = r_scr;
        w_push      = 1'b0;
        w_push_byte = w_in.write_data;
        w_sel_mem   = 1'b0;
        w_rd        = 8'h00;
        w_txv       = 1'b0;
        w_txb       = 8'h00;

        if (w_in.operation == OP_READ) begin
            unique case (w_in.offset)
                REG_DATA: begin
                    if (w_dlab) begin
                        w_rd = r_div[7:0];
                    end else if (r_count != '0) begin
                        w_sel_mem = 1'b1;
                        n_head    = f_next_idx(r_head);
                        n_count   = r_count - 1'b1;
                    end
                end
                REG_IER:  w_rd = w_dlab ? r_div[15:8] : {4'b0000, r_ier};
                REG_FIFO: w_rd = r_fen ? IIR_NONE_FIFO : IIR_NONE;
                REG_LCR:  w_rd = r_lcr;
                REG_MCR:  w_rd = {3'b000, r_mcr};
                REG_LSR: begin
                    w_rd  = LSR_TX_EMPTY | {6'b000000, r_ovr, (r_count != '0)};
                    n_ovr = 1'b0;
                end
                REG_MSR:  w_rd = w_msr;
                REG_SCR:  w_rd = r_scr;
                default:  w_rd = 8'h00;
            endcase
        end else if (w_in.operation == OP_WRITE) begin
            unique case (w_in.offset)
                REG_DATA: begin
                    if (w_dlab) begin
                        n_div[7:0] = w_in.write_data;
                    end else if (w_loop) begin
                        w_push = 1'b1;
                    end else begin
                        w_txv = 1'b1;
                        w_txb = w_in.write_data;
                    end
                end
                REG_IER: begin
                    if (w_dlab) begin
                        n_div[15:8] = w_in.write_data;
                    end else begin
                        n_ier = w_in.write_data[3:0];
                    end
                end
                REG_FIFO: begin
                    n_fen = w_in.write_data[0];
                    if (w_in.write_data[FCR_CLEAR_BIT]) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_count = '0;
                    end
                end
                REG_LCR: n_lcr = w_in.write_data;
                REG_MCR: n_mcr = w_in.write_data[4:0];
                REG_SCR: n_scr = w_in.write_data;
                default: ;
            endcase
        end else if (w_in.operation == OP_LINE) begin
            w_push      = !w_loop;
            w_push_byte = w_in.line_byte;
        end

        // push into the fifo, full drops the byte and flags overrun
        w_push_ok = 1'b0;
        if (w_push) begin
            if (r_count == FULL_CNT) begin
                n_ovr = 1'b1;
            end else begin
                w_push_ok = 1'b1;
                n_tail    = f_next_idx(r_tail);
                n_count   = r_count + 1'b1;
            end
        end
        w_push_ok = w_push_ok && w_in_fire;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div     <= '0;
            r_ier     <= '0;
            r_lcr     <= '0;
            r_mcr     <= '0;
            r_fen     <= 1'b0;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_ovr     <= 1'b0;
            r_scr     <= '0;
            r_m_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_div   <= n_div;
                r_ier   <= n_ier;
                r_lcr   <= n_lcr;
                r_mcr   <= n_mcr;
                r_fen   <= n_fen;
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
                r_ovr   <= n_ovr;
                r_scr   <= n_scr;
            end
            if (w_in_fire) begin
                r_m_valid <= 1'b1;
            end else if (!r_s_valid && w_out_fire) begin
                r_m_valid <= 1'b0;
            end
            // main result stalled while a new word comes in: park it in the skid
            if (w_in_fire && r_m_valid && !o_result.ready) begin
                r_s_valid <= 1'b1;
            end else if (r_s_valid && o_result.ready) begin
                r_s_valid <= 1'b0;
            end
        end
    end

    // fifo memory: write at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_tail] <= w_push_byte;
        end
        if (w_in_fire) begin
            r_mem_q <= r_mem[r_head];
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_m_sel_mem <= w_sel_mem;
            r_m_rd      <= w_rd;
            r_m_txv     <= w_txv;
            r_m_txb     <= w_txb;
        end
        if (w_in_fire && r_m_valid && !o_result.ready) begin
            r_s_word <= w_m_word;
        end
    end

    assign w_m_word.read_data = r_m_sel_mem ? r_mem_q : r_m_rd;
    assign w_m_word.tx_valid  = r_m_txv;
    assign w_m_word.tx_byte   = r_m_txb;

    assign o_result.valid = r_s_valid || r_m_valid;
    assign o_result.data  = r_s_valid ? r_s_word : w_m_word;

    // skid holds the older word, so the main stage is always occupied with the newer one
    a_skid_has_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid |-> r_m_valid)
        else $error("skid word without main word");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("fifo count beyond depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty fifo with split pointers");

    a_overrun_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_push && r_count == FULL_CNT) |=> r_ovr)
        else $error("push into full fifo did not flag overrun");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_ok |-> (r_count != FULL_CNT))
        else $error("memory write while fifo full");

endmodule
